// ===== rtl/futp_pkg.sv =====
// Shared types and protocol byte codes for the Firmata tunnel parser.
package futp_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [6:0] t_ver;

    localparam int unsigned MaxBeats = 5;
    localparam int unsigned BeatW    = $clog2(MaxBeats + 1);

    // Firmata command bytes
    localparam t_byte CMD_SYSEX_START = 8'hF0;
    localparam t_byte CMD_SYSEX_END   = 8'hF7;
    localparam t_byte CMD_UART_DATA   = 8'h66;
    localparam t_byte CMD_VERSION     = 8'hF9;
    localparam t_byte CMD_PIN_MODE    = 8'hF4;
    localparam t_byte CMD_PIN_VALUE   = 8'hF5;

    // high nibbles of channel commands
    localparam logic [3:0] NIB_ANALOG     = 4'hE;
    localparam logic [3:0] NIB_DIGITAL    = 4'h9;
    localparam logic [3:0] NIB_REP_ANALOG = 4'hC;
    localparam logic [3:0] NIB_REP_DIGITAL = 4'hD;

    // item and result kinds
    localparam logic OP_RECEIVE  = 1'b0;
    localparam logic OP_TRANSMIT = 1'b1;
    localparam logic KIND_LINK   = 1'b0;
    localparam logic KIND_UART   = 1'b1;

    // configuration register indexes
    localparam logic REG_VERSION_MAJOR = 1'b0;
    localparam logic REG_VERSION_MINOR = 1'b1;

    localparam t_ver VER_MAJOR_RST = 7'd1;
    localparam t_ver VER_MINOR_RST = 7'd6;

endpackage

// ===== rtl/firmata_uart_tunnel_parser_unit.sv =====
// Firmata link parser with tunnelled UART channel: input stage, decode, result burst.

// An item is taken into an input register and decoded into a burst of
// zero to five result bytes held in a shift register that drives the output port.
// The parser state advances when the item is decoded. A new item is accepted every
// cycle as long as the burst register is empty or is delivering its last byte; a
// transmit item (five bytes) and a version query (three bytes) give the longest
// bursts. Items that give no result pass at one per cycle while the burst register
// is empty.
module firmata_uart_tunnel_parser_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  futp_pkg::t_byte      s_axis_tdata,   // [7:0] data
    input  logic                 s_axis_tuser,   // [0] op
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output futp_pkg::t_byte      m_axis_tdata,   // [7:0] value
    output logic                 m_axis_tuser,   // [0] kind
    output logic                 m_axis_tlast,   // last result of the item
    // configuration
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  futp_pkg::t_ver       i_cfg_data
);
    import futp_pkg::*;

    // parser position
    localparam logic [2:0] PND_IDLE    = 3'd0;
    localparam logic [2:0] PND_SKIP1   = 3'd1;
    localparam logic [2:0] PND_SKIP2   = 3'd2;
    localparam logic [2:0] PND_SX_CMD  = 3'd3;
    localparam logic [2:0] PND_SX_BODY = 3'd4;

    localparam logic [1:0] TUN_OFF = 2'd0;
    localparam logic [1:0] TUN_LO  = 2'd1;
    localparam logic [1:0] TUN_HI  = 2'd2;

    t_ver r_ver_major;
    t_ver r_ver_minor;

    logic  r_in_valid;
    logic  r_in_op;
    t_byte r_in_data;

    logic [2:0] r_pending, n_pending;
    logic [1:0] r_tun, n_tun;
    t_ver       r_partial, n_partial;

    logic [BeatW-1:0]           r_cnt, n_cnt;
    logic [MaxBeats-1:0][7:0]   r_bytes, n_bytes;
    logic                       r_kind, n_kind;

    logic beat;
    logic take;

    assign beat = m_axis_tvalid && m_axis_tready;
    assign take = r_in_valid &&
                  ((r_cnt == '0) || ((r_cnt == BeatW'(1)) && m_axis_tready));

    assign s_axis_tready = !r_in_valid || take;

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_bytes[0];
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = (r_cnt == BeatW'(1));

    // decode of the held item
    always_comb begin
        n_pending = r_pending;
        n_tun     = r_tun;
        n_partial = r_partial;
        n_cnt     = '0;
        n_bytes   = '0;
        n_kind    = KIND_LINK;
        if (r_in_op == OP_TRANSMIT) begin
            n_cnt      = BeatW'(MaxBeats);
            n_bytes[0] = CMD_SYSEX_START;
            n_bytes[1] = CMD_UART_DATA;
            n_bytes[2] = {1'b0, r_in_data[6:0]};
            n_bytes[3] = {7'b0, r_in_data[7]};
            n_bytes[4] = CMD_SYSEX_END;
        end else begin
            case (r_pending)
                PND_SKIP2: begin
                    n_pending = PND_SKIP1;
                end
                PND_SKIP1: begin
                    n_pending = PND_IDLE;
                end
                PND_SX_CMD, PND_SX_BODY: begin
                    if (r_in_data == CMD_SYSEX_END) begin
                        n_pending = PND_IDLE;
                        n_tun     = TUN_OFF;
                    end else if (r_pending == PND_SX_CMD) begin
                        n_tun     = (r_in_data == CMD_UART_DATA) ? TUN_LO : TUN_OFF;
                        n_pending = PND_SX_BODY;
                    end else if (r_tun == TUN_LO) begin
                        n_partial = r_in_data[6:0];
                        n_tun     = TUN_HI;
                    end else if (r_tun == TUN_HI) begin
                        n_cnt      = BeatW'(1);
                        n_bytes[0] = {r_in_data[0], r_partial};
                        n_kind     = KIND_UART;
                        n_tun      = TUN_LO;
                    end
                end
                default: begin
                    if ((r_in_data[7:4] == NIB_ANALOG) || (r_in_data[7:4] == NIB_DIGITAL) ||
                        (r_in_data == CMD_PIN_MODE) || (r_in_data == CMD_PIN_VALUE)) begin
                        n_pending = PND_SKIP2;
                    end else if ((r_in_data[7:4] == NIB_REP_ANALOG) ||
                                 (r_in_data[7:4] == NIB_REP_DIGITAL)) begin
                        n_pending = PND_SKIP1;
                    end else if (r_in_data == CMD_SYSEX_START) begin
                        n_pending = PND_SX_CMD;
                    end else if (r_in_data == CMD_VERSION) begin
                        n_cnt      = BeatW'(3);
                        n_bytes[0] = CMD_VERSION;
                        n_bytes[1] = {1'b0, r_ver_major};
                        n_bytes[2] = {1'b0, r_ver_minor};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ver_major <= VER_MAJOR_RST;
            r_ver_minor <= VER_MINOR_RST;
            r_in_valid  <= 1'b0;
            r_pending   <= PND_IDLE;
            r_tun       <= TUN_OFF;
            r_partial   <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_VERSION_MAJOR) begin
                    r_ver_major <= i_cfg_data;
                end else begin
                    r_ver_minor <= i_cfg_data;
                end
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (take) begin
                r_pending <= n_pending;
                r_tun     <= n_tun;
                r_partial <= n_partial;
                r_cnt     <= n_cnt;
            end else if (beat) begin
                r_cnt <= r_cnt - BeatW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
        if (take) begin
            r_bytes <= n_bytes;
            r_kind  <= n_kind;
        end else if (beat) begin
            r_bytes <= {8'h00, r_bytes[MaxBeats-1:1]};
        end
    end

`ifndef NO_ASSERTIONS
    // burst count never runs past the longest burst
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= BeatW'(MaxBeats))
        else $error("burst count out of range");

    // tunnelling only inside a sysex body
    a_tun_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tun != TUN_OFF) |-> (r_pending == PND_SX_BODY))
        else $error("tunnel phase set outside sysex body");

    // a decoded UART byte is always the only result of its item
    a_uart_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_UART)) |-> m_axis_tlast)
        else $error("UART byte not alone in its burst");

    // a transmit item opens its frame with a sysex start byte
    a_tx_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (r_in_op == OP_TRANSMIT)) |=>
            (m_axis_tvalid && (m_axis_tdata == CMD_SYSEX_START)))
        else $error("transmit frame does not start with sysex start");
`endif

endmodule
